### rtl/core/led_pattern_sequencer_macros.svh
// ----------------------------------------------------------------------------
// LED pattern sequencer assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_MACROS_SVH
`define LED_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/lps_pkg.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared types, pattern codes, register indexes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  // pattern codes
  localparam logic [2:0] PAT_LEFT_DOT     = 3'd0;
  localparam logic [2:0] PAT_RIGHT_DOT    = 3'd1;
  localparam logic [2:0] PAT_LEFT_FILL    = 3'd2;
  localparam logic [2:0] PAT_RIGHT_FILL   = 3'd3;
  localparam logic [2:0] PAT_FLOWER_OPEN  = 3'd4;
  localparam logic [2:0] PAT_FLOWER_CLOSE = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_PERIOD = 2'd1;

  localparam int unsigned PERIOD_W = 10;
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RESET = 10'd30;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET = 10'd100;
  localparam logic [PERIOD_W-1:0] COUNT_MAX         = 10'd1023;

  localparam logic [3:0] LEN_LONG  = 4'd8;
  localparam logic [3:0] LEN_SHORT = 4'd4;

  // LED bit patterns
  localparam logic [7:0] LED_LOW_BIT    = 8'h01;
  localparam logic [7:0] LED_HIGH_BIT   = 8'h80;
  localparam logic [7:0] LED_CENTRE_UP  = 8'h10;
  localparam logic [7:0] LED_CENTRE_DN  = 8'h08;
  localparam logic [7:0] LED_UPPER_HALF = 8'hf0;
  localparam logic [7:0] LED_LOWER_HALF = 8'h0f;

  typedef struct packed {
    logic [PERIOD_W-1:0] fast;
    logic [PERIOD_W-1:0] slow;
  } periods_t;

  typedef struct packed {
    logic [2:0]          pattern;
    logic [3:0]          step;
    logic [PERIOD_W-1:0] count;
    logic [7:0]          led;
  } seq_state_t;

endpackage

`default_nettype wire

### rtl/core/lps_if.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer channels
// Valid/ready channels for tick items and LED result items.
// ----------------------------------------------------------------------------
`default_nettype none

// tick item channel
interface lps_item_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// result item channel
interface lps_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_bits;
  logic [2:0] pattern_number;
  logic       pattern_ended;

  modport source (output valid, output led_bits, output pattern_number,
                  output pattern_ended, input ready);
  modport sink   (input valid, input led_bits, input pattern_number,
                  input pattern_ended, output ready);
endinterface

`default_nettype wire

### rtl/core/led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer
// Steps eight LEDs through six chaser patterns, one tick item at a time.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Payload
//  item      sink       valid/ready    tick
//  result    source     valid/ready    led_bits, pattern_number, pattern_ended
//  cfg       sink       cfg_we         cfg_index, cfg_wdata
//
//  One item per clock while the result is not stalled: the step logic is plain
//  compare, shift and OR logic between the state registers and the result register.
//  An item is taken whenever the result register is empty or being emptied.
//  Synchronous reset clears the sequence state, periods go to 30 and 100.
//  A stalled result holds its register and stops further items.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_pattern_sequencer_macros.svh"

module led_pattern_sequencer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lps_item_if.sink                             item,
  lps_result_if.source                         result,
  input  wire logic                            cfg_we,
  input  wire logic [lps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lps_pkg::PERIOD_W-1:0]    cfg_wdata
);

  lps_pkg::periods_t   periods;
  lps_pkg::seq_state_t state;
  lps_pkg::seq_state_t state_next;
  logic                ended;
  logic                item_acc;
  logic                res_valid;
  logic [7:0]          res_led;
  logic [2:0]          res_pattern;
  logic                res_ended;

  lps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .periods  (periods)
  );

  lps_step u_step (
    .cur    (state),
    .periods(periods),
    .tick   (item.tick),
    .nxt    (state_next),
    .ended  (ended)
  );

  // accept when the result register is free this cycle
  assign item.ready = !res_valid || result.ready;
  assign item_acc   = item.valid && item.ready;

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (item_acc) begin
      state <= state_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_acc) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_acc) begin
      res_led     <= state_next.led;
      res_pattern <= state_next.pattern;
      res_ended   <= ended;
    end
  end

  assign result.valid          = res_valid;
  assign result.led_bits       = res_led;
  assign result.pattern_number = res_pattern;
  assign result.pattern_ended  = res_ended;

  // checks
  `LPS_ASSERT_IMP(a_pattern_range, clk, rst, 1'b1,
                  state.pattern <= lps_pkg::PAT_FLOWER_CLOSE, "pattern out of range")
  `LPS_ASSERT_IMP(a_step_range, clk, rst, 1'b1,
                  state.step <= lps_pkg::LEN_LONG, "step index out of range")
  `LPS_ASSERT_IMP(a_ended_clear, clk, rst, res_valid && res_ended,
                  res_led == 8'h00 && state.step == 4'd0, "pattern end without clear")
  `LPS_ASSERT_NXT(a_idle_tick, clk, rst, item_acc && !item.tick,
                  $stable(state), "state moved without a tick")

endmodule

`default_nettype wire

### rtl/core/lps_cfg.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer configuration registers
// Holds the fast and slow step periods written through the write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lps_pkg::PERIOD_W-1:0]    cfg_wdata,
  output lps_pkg::periods_t                   periods
);

  lps_pkg::periods_t regs;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.fast <= lps_pkg::FAST_PERIOD_RESET;
      regs.slow <= lps_pkg::SLOW_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lps_pkg::CFG_FAST_PERIOD: regs.fast <= cfg_wdata;
        lps_pkg::CFG_SLOW_PERIOD: regs.slow <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign periods = regs;

endmodule

`default_nettype wire

### rtl/core/lps_step.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer step logic
// Next state of counter, step, pattern and LEDs for one tick item.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_step (
  input  wire lps_pkg::seq_state_t cur,
  input  wire lps_pkg::periods_t   periods,
  input  wire logic                tick,
  output lps_pkg::seq_state_t      nxt,
  output logic                     ended
);

  logic [lps_pkg::PERIOD_W-1:0] cnt_inc;
  logic [lps_pkg::PERIOD_W-1:0] period;
  logic [3:0]                   length;
  logic [2:0]                   sh;
  logic [7:0]                   led_step;

  // saturating count, period and length of the active pattern
  assign cnt_inc = (cur.count == lps_pkg::COUNT_MAX) ? cur.count
                                                      : cur.count + 10'd1;
  assign period  = (cur.pattern == lps_pkg::PAT_FLOWER_OPEN) ? periods.slow
                                                              : periods.fast;
  assign length  = (cur.pattern == lps_pkg::PAT_FLOWER_OPEN ||
                    cur.pattern == lps_pkg::PAT_FLOWER_CLOSE) ? lps_pkg::LEN_SHORT
                                                               : lps_pkg::LEN_LONG;
  assign sh      = cur.step[2:0];

  // LED value for the current step
  always_comb begin
    case (cur.pattern)
      lps_pkg::PAT_RIGHT_DOT:   led_step = lps_pkg::LED_HIGH_BIT >> sh;
      lps_pkg::PAT_LEFT_FILL:   led_step = cur.led | (lps_pkg::LED_LOW_BIT << sh);
      lps_pkg::PAT_RIGHT_FILL:  led_step = cur.led | (lps_pkg::LED_HIGH_BIT >> sh);
      lps_pkg::PAT_FLOWER_OPEN: led_step = cur.led | (lps_pkg::LED_CENTRE_UP << sh)
                                                   | (lps_pkg::LED_CENTRE_DN >> sh);
      lps_pkg::PAT_FLOWER_CLOSE:
        led_step = ((lps_pkg::LED_UPPER_HALF >> sh) & lps_pkg::LED_UPPER_HALF) |
                   ((lps_pkg::LED_LOWER_HALF << sh) & lps_pkg::LED_LOWER_HALF);
      default:                  led_step = lps_pkg::LED_LOW_BIT << sh;
    endcase
  end

  // counter compare, then either a step or the move to the next pattern
  always_comb begin
    nxt   = cur;
    ended = 1'b0;
    if (tick) begin
      nxt.count = cnt_inc;
      if (cnt_inc >= period) begin
        nxt.count = '0;
        if (cur.step >= length) begin
          nxt.led     = '0;
          nxt.step    = '0;
          nxt.pattern = (cur.pattern >= lps_pkg::PAT_FLOWER_CLOSE) ? lps_pkg::PAT_LEFT_DOT
                                                                   : cur.pattern + 3'd1;
          ended       = 1'b1;
        end else begin
          nxt.led  = led_step;
          nxt.step = cur.step + 4'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern sequencer testbench
// Sends tick transactions through the item channel, steps a local copy of the
// chaser state for each accepted one and checks every result transaction in
// order. Directed tests cover reset state, register extremes and corner
// cases; random phases then vary both periods, idling and result stalls.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned MAX_PRINTED   = 40;

  typedef struct packed {
    logic [7:0] led;
    logic [2:0] pattern;
    logic       ended;
  } led_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_we;
  logic [lps_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lps_pkg::PERIOD_W-1:0]    cfg_wdata;

  lps_item_if   item_ch ();
  lps_result_if res_ch ();

  led_pattern_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // local copy of the chaser state and periods
  logic [lps_pkg::PERIOD_W-1:0] fast_per;
  logic [lps_pkg::PERIOD_W-1:0] slow_per;
  logic [2:0]                   chase_pat;
  logic [3:0]                   chase_step;
  logic [lps_pkg::PERIOD_W-1:0] chase_count;
  logic [7:0]                   chase_leds;

  led_view_t pending_leds[$];

  bit          gaps_on;
  bit          stalls_on;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned item_count;
  int unsigned idle_tick_count;
  int unsigned change_count;
  logic [5:0]  patterns_seen;

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_leds.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // one tick through the chaser: count, then step or change pattern
  function automatic led_view_t advance_chaser(input logic tick_val);
    logic [3:0]                   span;
    logic [lps_pkg::PERIOD_W-1:0] period;
    led_view_t                    r;
    r.ended = 1'b0;
    if (tick_val) begin
      if (chase_count < lps_pkg::COUNT_MAX) chase_count++;
      span = (chase_pat == lps_pkg::PAT_FLOWER_OPEN ||
              chase_pat == lps_pkg::PAT_FLOWER_CLOSE) ?
             lps_pkg::LEN_SHORT : lps_pkg::LEN_LONG;
      period = (chase_pat == lps_pkg::PAT_FLOWER_OPEN) ? slow_per : fast_per;
      if (chase_count >= period) begin
        chase_count = '0;
        if (chase_step >= span) begin
          chase_leds = '0;
          chase_step = '0;
          chase_pat  = (chase_pat >= lps_pkg::PAT_FLOWER_CLOSE) ? lps_pkg::PAT_LEFT_DOT
                                                                : chase_pat + 3'd1;
          r.ended    = 1'b1;
        end else begin
          case (chase_pat)
            lps_pkg::PAT_RIGHT_DOT:
              chase_leds = lps_pkg::LED_HIGH_BIT >> chase_step;
            lps_pkg::PAT_LEFT_FILL:
              chase_leds = chase_leds | (lps_pkg::LED_LOW_BIT << chase_step);
            lps_pkg::PAT_RIGHT_FILL:
              chase_leds = chase_leds | (lps_pkg::LED_HIGH_BIT >> chase_step);
            lps_pkg::PAT_FLOWER_OPEN:
              chase_leds = chase_leds | (lps_pkg::LED_CENTRE_UP << chase_step)
                           | (lps_pkg::LED_CENTRE_DN >> chase_step);
            lps_pkg::PAT_FLOWER_CLOSE:
              chase_leds = ((lps_pkg::LED_UPPER_HALF >> chase_step) & lps_pkg::LED_UPPER_HALF)
                           | ((lps_pkg::LED_LOWER_HALF << chase_step)
                              & lps_pkg::LED_LOWER_HALF);
            default:
              chase_leds = lps_pkg::LED_LOW_BIT << chase_step;
          endcase
          chase_step++;
        end
      end
    end
    r.led     = chase_leds;
    r.pattern = chase_pat;
    return r;
  endfunction

  // one item transaction; valid is left high for the next call to decide
  task automatic send_tick(input logic tick_val);
    int unsigned gap;
    led_view_t   want;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.tick  <= tick_val;
    do @(posedge clk); while (!item_ch.ready);
    want = advance_chaser(tick_val);
    pending_leds.push_back(want);
    item_count++;
    if (!tick_val) idle_tick_count++;
    if (want.ended) change_count++;
    patterns_seen[want.pattern] = 1'b1;
  endtask

  // drop valid and wait for every outstanding result, plus the pipeline
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register write; only called once the block is idle
  task automatic write_reg(input logic [lps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lps_pkg::PERIOD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      lps_pkg::CFG_FAST_PERIOD: fast_per = val;
      lps_pkg::CFG_SLOW_PERIOD: slow_per = val;
      default: ;
    endcase
  endtask

  // mostly short periods so the run reaches every pattern, now and then long ones
  function automatic logic [lps_pkg::PERIOD_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return lps_pkg::COUNT_MAX;
    if (r == 1) return lps_pkg::PERIOD_W'($urandom_range(0, 1023));
    if (r <= 4) return lps_pkg::PERIOD_W'($urandom_range(5, 40));
    return lps_pkg::PERIOD_W'($urandom_range(0, 3));
  endfunction

  // result side: random stalls, in-order check of each transaction
  task automatic check_result();
    led_view_t want;
    if (pending_leds.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: led=%h pattern=%0d ended=%b",
                                res_ch.led_bits, res_ch.pattern_number,
                                res_ch.pattern_ended));
      return;
    end
    want = pending_leds.pop_front();
    checked_count++;
    if (res_ch.led_bits !== want.led)
      report_mismatch($sformatf("led_bits %h, wanted %h", res_ch.led_bits, want.led));
    if (res_ch.pattern_number !== want.pattern)
      report_mismatch($sformatf("pattern_number %0d, wanted %0d",
                                res_ch.pattern_number, want.pattern));
    if (res_ch.pattern_ended !== want.ended)
      report_mismatch($sformatf("pattern_ended %b, wanted %b",
                                res_ch.pattern_ended, want.ended));
  endtask

  initial begin : result_sink
    int unsigned stall;
    res_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      check_result();
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset values: report-only items, then a few counts at the reset periods
  task automatic test_reset_state();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_tick(1'b0);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    // hold off until every result is back
    wait_idle();
  endtask

  // all-ones periods and writes to unused indexes, which must be ignored
  task automatic test_register_extremes();
    write_reg(lps_pkg::CFG_FAST_PERIOD, lps_pkg::COUNT_MAX);
    write_reg(lps_pkg::CFG_SLOW_PERIOD, lps_pkg::COUNT_MAX);
    write_reg(lps_pkg::CFG_INDEX_W'(2), '0);
    write_reg(lps_pkg::CFG_INDEX_W'(3), lps_pkg::PERIOD_W'(10'h155));
    write_reg(lps_pkg::CFG_INDEX_W'(3), lps_pkg::PERIOD_W'(10'h2aa));
    stalls_on = 1'b1;
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    wait_idle();
  endtask

  // period dropped below the running count: the next tick steps at once
  task automatic test_period_lowered();
    write_reg(lps_pkg::CFG_FAST_PERIOD, lps_pkg::PERIOD_W'(2));
    gaps_on = 1'b1;
    repeat (3) send_tick(1'b1);
    wait_idle();
  endtask

  // zero periods step on every tick, through the end of the first pattern
  task automatic test_period_zero();
    write_reg(lps_pkg::CFG_FAST_PERIOD, '0);
    write_reg(lps_pkg::CFG_SLOW_PERIOD, '0);
    repeat (10) send_tick(1'b1);
    wait_idle();
  endtask

  // random phases: new periods, idling mix and tick density per phase
  task automatic test_random_phases();
    int unsigned done;
    int unsigned len;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) write_reg(lps_pkg::CFG_FAST_PERIOD, pick_period());
      if ($urandom_range(0, 3) != 0) write_reg(lps_pkg::CFG_SLOW_PERIOD, pick_period());
      if ($urandom_range(0, 9) == 0)
        write_reg(lps_pkg::CFG_INDEX_W'($urandom_range(2, 3)),
                  lps_pkg::PERIOD_W'($urandom_range(0, 1023)));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(30, 120);
      repeat (len) begin
        send_tick($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 59) == 0) wait_idle();
      end
      done += len;
    end
    wait_idle();
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.tick  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    mismatch_count  = 0;
    checked_count   = 0;
    item_count      = 0;
    idle_tick_count = 0;
    change_count    = 0;
    patterns_seen   = '0;
    fast_per    = lps_pkg::FAST_PERIOD_RESET;
    slow_per    = lps_pkg::SLOW_PERIOD_RESET;
    chase_pat   = lps_pkg::PAT_LEFT_DOT;
    chase_step  = '0;
    chase_count = '0;
    chase_leds  = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_extremes();
    test_period_lowered();
    test_period_zero();
    test_random_phases();

    $display("Covered %0d tick transactions (%0d without time passing), %0d results checked.",
             item_count, idle_tick_count, checked_count);
    $display("Pattern changes: %0d, patterns reached (bit per pattern): %06b.",
             change_count, patterns_seen);
    if (mismatch_count == 0 && pending_leds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count,
               pending_leds.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
